FILE: src/sodds_pkg.sv
// ----------------------------------------------------------------------------
// sodds_pkg
// Shared constants and elaboration-time sine table math for the DDS oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package sodds_pkg;

    // Default sizing of the oscillator
    localparam int PHASE_BITS_DEF       = 32;
    localparam int TABLE_INDEX_BITS_DEF = 12;
    localparam int SAMPLE_BITS_DEF      = 16;

    // Configuration register file
    localparam int STEP_W      = 32;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 15;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_GAIN = 1'd1;

    localparam logic [STEP_W-1:0] PHASE_STEP_RESET  = 32'd39370534;
    localparam logic [GAIN_W-1:0] OUTPUT_GAIN_RESET = 16'd8192;

    // pi/2 in Q62 and the Taylor series denominators (2n)(2n+1), n = 1..13
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam int          TAYLOR_TERMS = 13;
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
        64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
    };

    // (a*b) >> 62 for Q62 operands whose product stays below 4
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[125:62];
    endfunction

    // sine of an angle in [0, pi/2], Q62 in and out
    function automatic logic [63:0] sine_q62(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (int n = 0; n < TAYLOR_TERMS; n++)
        begin
            term = mul_q62(term, x2) / TAYLOR_DIV[n];
            if ((n % 2) == 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    // Quarter-wave table entry k: round(A * sin(k * pi/2 / quarter)), half away from zero
    function automatic logic [31:0] sine_mag(input int index_bits, input int sample_bits,
                                             input int k);
        logic [63:0]  unit;
        logic [63:0]  angle;
        logic [63:0]  amp;
        logic [127:0] p;
        int           qshift;
        int           quarter;
        qshift  = index_bits - 2;
        quarter = 1 << qshift;
        unit    = HALF_PI_Q62 >> qshift;
        angle   = (k == quarter) ? HALF_PI_Q62 : unit * 64'(k);
        amp     = (64'd1 << (sample_bits - 1)) - 64'd1;
        p       = 128'(sine_q62(angle)) * 128'(amp);
        p       = p + (128'd1 << 61);
        return p[93:62];
    endfunction

endpackage

`default_nettype wire

FILE: src/sodds_phase.sv
// ----------------------------------------------------------------------------
// sodds_phase
// Phase accumulator stage: advance the phase by the tuning word on each tick.
// ----------------------------------------------------------------------------
`default_nettype none

module sodds_phase
    import sodds_pkg::*;
#(
    parameter int PHASE_BITS       = PHASE_BITS_DEF,
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        tick,
    input  wire logic [STEP_W-1:0]           phase_step,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [TABLE_INDEX_BITS-1:0]      table_index
);

    localparam int EXT_W = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

    logic [EXT_W-1:0]      step_wide;
    logic [PHASE_BITS-1:0] step_mod;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic                  advance;

    // tuning word taken modulo a full turn
    assign step_wide = EXT_W'(phase_step);
    assign step_mod  = step_wide[PHASE_BITS-1:0];

    assign in_ready = !valid_reg || out_ready;
    assign advance  = in_valid && in_ready && tick;

    always_comb
    begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = advance;
        end
        if (advance)
        begin
            phase_next = phase_reg + step_mod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid   = valid_reg;
    assign table_index = phase_reg[PHASE_BITS-1 -: TABLE_INDEX_BITS];

endmodule

`default_nettype wire

FILE: src/sodds_sine_rom.sv
// ----------------------------------------------------------------------------
// sodds_sine_rom
// Quarter-wave sine lookup with quadrant folding and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sodds_sine_rom
    import sodds_pkg::*;
#(
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF,
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [TABLE_INDEX_BITS-1:0] table_index,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             sine_neg,
    output logic [SAMPLE_BITS-2:0]           sine_mag_out
);

    localparam int MAG_W   = SAMPLE_BITS - 1;
    localparam int ADDR_W  = TABLE_INDEX_BITS - 1;
    localparam int R_W     = TABLE_INDEX_BITS - 2;
    localparam int QUARTER = 1 << R_W;
    localparam int DEPTH   = QUARTER + 1;
    localparam logic [ADDR_W-1:0] QUARTER_A = ADDR_W'(QUARTER);

    logic [MAG_W-1:0]  rom_table [DEPTH];
    logic [1:0]        quad;
    logic [ADDR_W-1:0] r_ext;
    logic [ADDR_W-1:0] addr;
    logic              advance;
    logic              valid_reg;
    logic              valid_next;
    logic              neg_reg;
    logic [MAG_W-1:0]  mag_reg;

    // constant quarter-wave table, one extra entry for the peak
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_rom
        localparam logic [31:0] ENTRY = sine_mag(TABLE_INDEX_BITS, SAMPLE_BITS, g);
        assign rom_table[g] = ENTRY[MAG_W-1:0];
    end

    // fold the full turn onto the first quadrant
    assign quad  = table_index[TABLE_INDEX_BITS-1 -: 2];
    assign r_ext = {1'b0, table_index[R_W-1:0]};
    assign addr  = quad[0] ? (QUARTER_A - r_ext) : r_ext;

    assign in_ready = !valid_reg || out_ready;
    assign advance  = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mag_reg <= rom_table[addr];
            neg_reg <= quad[1];
        end
    end

    assign out_valid    = valid_reg;
    assign sine_neg     = neg_reg;
    assign sine_mag_out = mag_reg;

endmodule

`default_nettype wire

FILE: src/sodds_scale.sv
// ----------------------------------------------------------------------------
// sodds_scale
// Gain stage: multiply by the Q1.15 gain, floor, saturate, hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sodds_scale
    import sodds_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   sine_neg,
    input  wire logic [SAMPLE_BITS-2:0] sine_mag_in,
    input  wire logic [GAIN_W-1:0]      output_gain,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [SAMPLE_BITS-1:0]      sample
);

    localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
    localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(1 << (SAMPLE_BITS - 1));

    logic signed [SAMPLE_BITS-1:0] sine_s;
    logic signed [GAIN_W:0]        gain_s;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      scaled;
    logic [SAMPLE_BITS-1:0]        sample_next;
    logic [SAMPLE_BITS-1:0]        sample_reg;
    logic                          valid_reg;
    logic                          valid_next;
    logic                          advance;

    assign sine_s = sine_neg ? -$signed({1'b0, sine_mag_in}) : $signed({1'b0, sine_mag_in});
    assign gain_s = $signed({1'b0, output_gain});
    assign prod   = PROD_W'(sine_s) * PROD_W'(gain_s);
    assign scaled = prod >>> GAIN_FRAC;

    always_comb
    begin
        priority if (scaled > SAT_MAX)
            sample_next = SAT_MAX[SAMPLE_BITS-1:0];
        else if (scaled < SAT_MIN)
            sample_next = SAT_MIN[SAMPLE_BITS-1:0];
        else
            sample_next = scaled[SAMPLE_BITS-1:0];
    end

    assign in_ready = !valid_reg || out_ready;
    assign advance  = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sample_reg <= sample_next;
        end
    end

    assign out_valid = valid_reg;
    assign sample    = sample_reg;

endmodule

`default_nettype wire

FILE: src/sine_oscillator_dds_core.sv
// ----------------------------------------------------------------------------
// sine_oscillator_dds_core
// Direct digital synthesis sine oscillator with a stereo output stream.
// ----------------------------------------------------------------------------
// Each request on the slave stream with tdata bit 0 set advances a
// PHASE_BITS-wide phase accumulator by phase_step (wrapping modulo a full
// turn) and yields one stereo frame: the top TABLE_INDEX_BITS phase bits
// select a sine value from a quarter-wave table (2^(TABLE_INDEX_BITS-2)+1
// entries, built at elaboration), which is scaled by the Q1.15 output_gain,
// floored and saturated to SAMPLE_BITS. Left and right samples are equal.
// A request with bit 0 clear is taken but moves nothing and yields no frame.
// The datapath is three register stages (phase, table read, gain), and one
// request is taken every cycle while the master side keeps up. Write
// phase_step and output_gain only while idle.
`default_nettype none

module sine_oscillator_dds_core
    import sodds_pkg::*;
#(
    parameter int PHASE_BITS       = PHASE_BITS_DEF,
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF,
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
)
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    // request stream
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    input  wire logic [7:0]                              s_tdata,   // [0] tick
    // stereo sample stream
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]           m_tdata,   // left_sample, right_sample
    // configuration write port
    input  wire logic                                    cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                   cfg_data
);

    localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    logic [STEP_W-1:0]           phase_step_reg;
    logic [GAIN_W-1:0]           output_gain_reg;

    logic                        ph_valid;
    logic                        ph_ready;
    logic [TABLE_INDEX_BITS-1:0] ph_index;

    logic                        rom_valid;
    logic                        rom_ready;
    logic                        rom_neg;
    logic [SAMPLE_BITS-2:0]      rom_mag;

    logic [SAMPLE_BITS-1:0]      sample;

    // Configuration registers: take a write whenever the enable is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= PHASE_STEP_RESET;
            output_gain_reg <= OUTPUT_GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PHASE_STEP:  phase_step_reg  <= cfg_data[STEP_W-1:0];
                REG_OUTPUT_GAIN: output_gain_reg <= cfg_data[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Stage 1: advance the phase on every tick request
    sodds_phase #(
        .PHASE_BITS       (PHASE_BITS),
        .TABLE_INDEX_BITS (TABLE_INDEX_BITS)
    ) u_phase (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .tick        (s_tdata[0]),
        .phase_step  (phase_step_reg),
        .out_valid   (ph_valid),
        .out_ready   (ph_ready),
        .table_index (ph_index)
    );

    // Stage 2: fold into the first quadrant and read the sine table
    sodds_sine_rom #(
        .TABLE_INDEX_BITS (TABLE_INDEX_BITS),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_rom (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (ph_valid),
        .in_ready     (ph_ready),
        .table_index  (ph_index),
        .out_valid    (rom_valid),
        .out_ready    (rom_ready),
        .sine_neg     (rom_neg),
        .sine_mag_out (rom_mag)
    );

    // Stage 3: apply the gain and hold the frame for the master side
    sodds_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (rom_valid),
        .in_ready    (rom_ready),
        .sine_neg    (rom_neg),
        .sine_mag_in (rom_mag),
        .output_gain (output_gain_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .sample      (sample)
    );

    // Left in the low half, right above it, zero fill to whole bytes
    assign m_tdata = OUT_W'({sample, sample});

endmodule

`default_nettype wire

FILE: dv/sodds_frame_checker.sv
// ----------------------------------------------------------------------------
// sodds_frame_checker
// Predicts the stereo frames of the DDS oscillator and checks them as they
// leave it.
// ----------------------------------------------------------------------------
// Tracks the register writes, advances a private phase accumulator on every
// accepted tick request and queues the frame it expects. Each accepted frame
// on the sample stream is checked field by field against the oldest frame in
// that queue.
module sodds_frame_checker
    import sodds_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [7:0]             s_tdata,     // [0] tick
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [31:0]            m_tdata,     // [15:0] left, [31:16] right
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          mismatches,
    output int                          frames_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     INDEX_BITS = TABLE_INDEX_BITS_DEF;
    localparam int     TABLE_LEN  = 1 << INDEX_BITS;
    localparam int     QUARTER    = TABLE_LEN / 4;
    localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS_DEF - 1)) - 1;
    localparam longint SAMPLE_MIN = -(64'sd1 <<< (SAMPLE_BITS_DEF - 1));

    typedef struct packed {
        logic signed [SAMPLE_BITS_DEF-1:0] right;
        logic signed [SAMPLE_BITS_DEF-1:0] left;
    } stereo_frame_t;

    int                         sine_table [TABLE_LEN];
    logic [PHASE_BITS_DEF-1:0]  phase_acc;
    logic [STEP_W-1:0]          step_reg;
    logic [GAIN_W-1:0]          gain_reg;
    stereo_frame_t              expected_frames [$];

    function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = {64'd0, a} * {64'd0, b};
        return wide[125:62];
    endfunction

    // Magnitude of quarter-wave entry k, rounded half away from zero.
    function automatic int quarter_wave_mag(input int k);
        logic [63:0]  angle;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  acc;
        logic [127:0] wide;
        angle = (k == QUARTER) ? HALF_PI_Q62 : (HALF_PI_Q62 >> (INDEX_BITS - 2)) * 64'(k);
        x2    = q62_product(angle, angle);
        term  = angle;
        acc   = angle;
        for (int n = 1; n <= TAYLOR_TERMS; n++)
        begin
            term = q62_product(term, x2) / 64'((2 * n) * (2 * n + 1));
            acc  = (n % 2 == 1) ? acc - term : acc + term;
        end
        wide = {64'd0, acc} * 128'(SAMPLE_MAX) + (128'd1 << 61);
        return int'(wide[93:62]);
    endfunction

    // Scale one table value by the gain, floor, saturate, duplicate to both channels.
    function automatic stereo_frame_t scaled_frame(input int table_value,
                                                   input logic [GAIN_W-1:0] gain);
        longint        level;
        stereo_frame_t frame;
        level = (longint'(table_value) * longint'({48'd0, gain})) >>> GAIN_FRAC;
        if (level > SAMPLE_MAX)
            level = SAMPLE_MAX;
        else if (level < SAMPLE_MIN)
            level = SAMPLE_MIN;
        frame.left  = level[SAMPLE_BITS_DEF-1:0];
        frame.right = level[SAMPLE_BITS_DEF-1:0];
        return frame;
    endfunction

    initial
    begin
        int quad;
        int r;
        int mag;
        for (int i = 0; i < TABLE_LEN; i++)
        begin
            quad = (i / QUARTER) % 4;
            r    = i % QUARTER;
            mag  = quarter_wave_mag((quad % 2 == 1) ? QUARTER - r : r);
            sine_table[i] = (quad >= 2) ? -mag : mag;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        stereo_frame_t want;
        stereo_frame_t got;
        if (!rst_n)
        begin
            phase_acc  = '0;
            step_reg   = PHASE_STEP_RESET;
            gain_reg   = OUTPUT_GAIN_RESET;
            mismatches = 0;
            expected_frames.delete();
        end
        else
        begin
            // check outgoing frames first: a frame never belongs to a request of this edge
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[2*SAMPLE_BITS_DEF-1:0];
                if (expected_frames.size() == 0)
                begin
                    $error("unexpected frame: left %0d right %0d", got.left, got.right);
                    mismatches++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (got.left !== want.left)
                    begin
                        $error("left_sample: expected %0d, actual %0d", want.left, got.left);
                        mismatches++;
                    end
                    if (got.right !== want.right)
                    begin
                        $error("right_sample: expected %0d, actual %0d", want.right, got.right);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready && s_tdata[0])
            begin
                phase_acc = phase_acc + step_reg;
                expected_frames.insert(expected_frames.size(), scaled_frame(
                    sine_table[phase_acc[PHASE_BITS_DEF-1 -: INDEX_BITS]], gain_reg));
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PHASE_STEP:  step_reg = cfg_data[STEP_W-1:0];
                    REG_OUTPUT_GAIN: gain_reg = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
        frames_due = expected_frames.size();
    end

endmodule

FILE: dv/sine_oscillator_dds_core_test.sv
// ----------------------------------------------------------------------------
// sine_oscillator_dds_core_test
// Stimulus and verdict for the DDS sine oscillator core.
// ----------------------------------------------------------------------------
// Drives tick requests into the oscillator under a series of tuning word and
// gain settings, from a directed opening (quarter-turn steps, full-scale and
// saturating gains, zero step, tick requests that must be dropped) to long
// random phases. Both stream sides idle at random; the frame checker beside
// the core predicts every frame and counts the mismatches.
module sine_oscillator_dds_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sodds_pkg::*;

    localparam int FRAME_W       = ((2 * SAMPLE_BITS_DEF + 7) / 8) * 8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_FRAMES = 1500;
    // three register stages, rounded up generously
    localparam int SETTLE_CYCLES = 12;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [FRAME_W-1:0]     m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_PHASE_STEP;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int mismatches;
    int frames_due;
    int cycle_count = 0;
    int stall_left = 0;
    int calm_left = 0;
    bit sender_calm = 1'b0;

    sine_oscillator_dds_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sodds_frame_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .frames_due (frames_due)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop: far beyond the slowest correct run with the longest gaps and stalls.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else if (pick < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Back-pressure on the sample stream: random stalls, broken by calm
    // stretches where tready stays high so the core runs at full rate.
    always @(posedge clk)
    begin
        if (calm_left > 0)
        begin
            m_tready  <= 1'b1;
            calm_left <= calm_left - 1;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            case ($urandom_range(0, 19))
                0:       calm_left <= $urandom_range(50, 300);
                1, 2, 3: stall_left <= idle_length();
                default: ;
            endcase
        end
    end

    // Issue one request, with a random gap ahead of it unless the sender is calm.
    // tvalid stays high afterwards so back-to-back requests need no toggle.
    task automatic issue_request(input bit tick);
        int gap;
        gap = sender_calm ? 0 : idle_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, tick};
        @(posedge clk iff s_tready);
    endtask

    // Drop tvalid, drain all expected frames, then give dropped ticks time to pass.
    task automatic drain_core();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (frames_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers while the core is idle.
    task automatic program_oscillator(input logic [STEP_W-1:0] step,
                                      input logic [GAIN_W-1:0] gain);
        drain_core();
        cfg_we    <= 1'b1;
        cfg_index <= REG_PHASE_STEP;
        cfg_data  <= step;
        @(posedge clk);
        cfg_index <= REG_OUTPUT_GAIN;
        cfg_data  <= {{(CFG_DATA_W - GAIN_W){1'b0}}, gain};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 6))
            0:       return $urandom_range(0, 32'h003F_FFFF);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 32'h003F_FFFF);
            2:       return 32'($urandom_range(0, 4095)) << 20;
            3:       return 32'h8000_0000;
            4:       return 32'($urandom_range(0, 3));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 6))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'hFFFF;
            3:       return 16'($urandom_range(32769, 65535));
            4:       return 16'($urandom_range(0, 32768));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        int frames_sent;
        int phase_len;
        bit tick;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings, including a dropped tick that must not move the phase.
        issue_request(1'b1);
        issue_request(1'b0);
        issue_request(1'b1);
        issue_request(1'b1);

        // Quarter-turn steps at unity gain: visit all four quadrants.
        program_oscillator(32'h4000_0000, 16'd32768);
        repeat (5) issue_request(1'b1);

        // Largest step (phase walks backward, wraps) with the largest gain: saturate high.
        program_oscillator(32'hFFFF_FFFF, 16'hFFFF);
        issue_request(1'b1);
        issue_request(1'b0);
        issue_request(1'b1);
        issue_request(1'b1);

        // Half-turn step alternates between the two halves: saturate low and high.
        program_oscillator(32'h8000_0000, 16'hFFFF);
        repeat (2) issue_request(1'b1);

        // Zero step and zero gain: frozen phase, silent output.
        program_oscillator(32'd0, 16'd0);
        repeat (2) issue_request(1'b1);

        // Smallest nonzero step and gain: floor rounds positive values down to 0.
        program_oscillator(32'd1, 16'd1);
        repeat (2) issue_request(1'b1);

        // One table entry per tick just below unity gain.
        program_oscillator(32'h0010_0000, 16'd32767);
        repeat (3) issue_request(1'b1);

        // Random phases: new settings each time, mostly ticks with some dropped ones.
        frames_sent = 0;
        while (frames_sent < RANDOM_FRAMES)
        begin
            program_oscillator(pick_step(), pick_gain());
            sender_calm = ($urandom_range(0, 3) == 0);
            phase_len   = $urandom_range(50, 250);
            repeat (phase_len)
            begin
                tick = ($urandom_range(0, 9) != 0);
                issue_request(tick);
                if (tick)
                    frames_sent++;
            end
        end

        drain_core();

        if (mismatches == 0 && frames_due == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
